FILE: rtl/core/dependency_graph_topological_order_defines.svh
// assertion macros shared by the topological order rtl
// no dependencies; expects clk and rst in the including scope
`ifndef DEPENDENCY_GRAPH_TOPOLOGICAL_ORDER_DEFINES_SVH
`define DEPENDENCY_GRAPH_TOPOLOGICAL_ORDER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DGTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define DGTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dgto_pkg.sv
// shared types for the topological order block: commands, status codes,
// controller states and the controller/datapath command and status bundles
`timescale 1ns / 1ps

package dgto_pkg;

  localparam int KEY_W = 16;

  typedef enum logic [1:0] {
    CMD_ADD_NODE = 2'd0,
    CMD_ADD_EDGE = 2'd1,
    CMD_TAKE     = 2'd2,
    CMD_CLEAR    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOOKUP,
    S_EDGE_APPEND,
    S_EDGE_INC,
    S_READY_SCAN,
    S_EDGE_SCAN,
    S_MARK,
    S_RESPOND
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    add_node;
    logic    clear;
    logic    scan_start;
    logic    lookup_run;
    logic    edge_append;
    logic    edge_inc;
    logic    ready_run;
    logic    edge_run;
    logic    mark;
    logic    res_wr;
    logic    res_found;
    status_t res_status;
    logic    load_out;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic node_full;
    logic edge_full;
    logic lookup_done;
    logic src_hit;
    logic tgt_hit;
    logic ready_done;
    logic ready_hit;
    logic edge_done;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/core/dependency_graph_topological_order.sv
// Incremental Kahn topological ordering over a bounded node and edge store. Commands add a
// node, add a dependency edge by source and target key, take the next ready node in
// insertion order, or clear both stores. One item is worked on at a time and gives exactly
// one result; a new item is taken while the previous result still waits on the output.
// Each item steps through the controller states: add node and clear go from dispatch
// straight to the response. Add edge runs the key lookup, which reads one node per cycle
// through the key memory's single read port, then appends the edge and raises the target's
// pending count when the edge is stored, or goes straight to the response when refused.
// Take-next reads one node state per cycle for the ready search, then one edge per cycle
// while the pending counts of the targets are lowered through the node state memory;
// with no node ready it responds after the search. The next item can be taken in the
// cycle after the result is loaded.
// top level: joins dgto_ctrl and dgto_datapath; uses dgto_pkg
`timescale 1ns / 1ps

module dependency_graph_topological_order #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int KEY_BITS  = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [dgto_pkg::KEY_W-1:0] column_key,
  input  logic [dgto_pkg::KEY_W-1:0] target_key,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       found,
  output logic [dgto_pkg::KEY_W-1:0] ready_key,
  output logic [1:0]                 status
);

  dgto_pkg::ctrl_t ctrl;
  dgto_pkg::stat_t stat;

  dgto_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  dgto_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES),
    .KEY_BITS  (KEY_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .column_key (column_key),
    .target_key (target_key),
    .out_stall  (out_stall),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_valid  (out_valid),
    .found      (found),
    .ready_key  (ready_key),
    .status     (status)
  );

endmodule

FILE: rtl/core/dgto_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module dgto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/dgto_datapath.sv
// datapath: node key, node state and edge memories, fill counters, scan
// pipelines and result register; uses dgto_pkg, dgto_ram and the defines header
`timescale 1ns / 1ps
`include "dependency_graph_topological_order_defines.svh"

module dgto_datapath #(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 256,
  parameter int KEY_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [1:0]                  cmd,
  input  logic [dgto_pkg::KEY_W-1:0]  column_key,
  input  logic [dgto_pkg::KEY_W-1:0]  target_key,
  input  logic                        out_stall,
  input  dgto_pkg::ctrl_t             ctrl,
  output dgto_pkg::stat_t             stat,
  output logic                        out_valid,
  output logic                        found,
  output logic [dgto_pkg::KEY_W-1:0]  ready_key,
  output logic [1:0]                  status
);

  localparam int KW   = dgto_pkg::KEY_W;
  localparam int NA_W = $clog2(MAX_NODES);
  localparam int NF_W = $clog2(MAX_NODES + 1);
  localparam int EA_W = $clog2(MAX_EDGES);
  localparam int EF_W = $clog2(MAX_EDGES + 1);
  localparam int PC_W = $clog2(MAX_EDGES + 1);
  localparam int SW   = PC_W + 1;
  localparam int EW   = 2 * NA_W;

  // latched command
  dgto_pkg::cmd_t      cmd_r;
  logic [KEY_BITS-1:0] skey;
  logic [KEY_BITS-1:0] tkey;

  logic [NF_W-1:0] node_fill;
  logic [EF_W-1:0] edge_fill;

  // node scan
  logic [NF_W-1:0] ncnt;
  logic            n_pv;
  logic [NA_W-1:0] n_paddr;
  logic            src_hit;
  logic            tgt_hit;
  logic [NA_W-1:0] src_slot;
  logic [NA_W-1:0] tgt_slot;
  logic            rdy_hit;
  logic [NA_W-1:0] sel_slot;
  logic [KEY_BITS-1:0] sel_key;

  // edge scan and decrement pipeline
  logic [EF_W-1:0] ecnt;
  logic            e_pv;
  logic            d_pv;
  logic [NA_W-1:0] d_addr;
  logic            fwd_valid;
  logic [NA_W-1:0] fwd_addr;
  logic [SW-1:0]   fwd_data;

  logic               res_found;
  dgto_pkg::status_t  res_status;
  dgto_pkg::status_t  status_r;

  // memory ports
  logic [KEY_BITS-1:0] key_rdata;
  logic [SW-1:0]       st_rdata;
  logic [EW-1:0]       edge_rdata;
  logic                st_we;
  logic [NA_W-1:0]     st_waddr;
  logic [SW-1:0]       st_wdata;
  logic [NA_W-1:0]     st_raddr;
  logic                key_we;
  logic [NA_W-1:0]     es;
  logic [NA_W-1:0]     et;

  logic          node_full;
  logic          edge_full;
  logic          n_issue;
  logic          e_issue;
  logic          hit_now;
  logic          e_match;
  logic [SW-1:0] dec_cur;
  logic          dec_we;

  assign node_full = (node_fill >= NF_W'(MAX_NODES));
  assign edge_full = (edge_fill >= EF_W'(MAX_EDGES));
  assign es        = edge_rdata[EW-1:NA_W];
  assign et        = edge_rdata[NA_W-1:0];
  assign key_we    = ctrl.add_node && !node_full;

  assign n_issue = (ctrl.lookup_run || (ctrl.ready_run && !rdy_hit)) && (ncnt < node_fill);
  assign e_issue = ctrl.edge_run && (ecnt < edge_fill);
  assign hit_now = ctrl.ready_run && n_pv && !rdy_hit &&
                   (st_rdata[PC_W-1:0] == '0) && !st_rdata[SW-1];
  assign e_match = ctrl.edge_run && e_pv && (es == sel_slot);

  // a write in the previous cycle is not yet visible at the read port
  assign dec_cur = (fwd_valid && (fwd_addr == d_addr)) ? fwd_data : st_rdata;
  assign dec_we  = ctrl.edge_run && d_pv && (dec_cur[PC_W-1:0] != '0);

  always_comb begin
    if (ctrl.edge_run) begin
      st_raddr = et;
    end else if (ctrl.edge_append) begin
      st_raddr = tgt_slot;
    end else begin
      st_raddr = ncnt[NA_W-1:0];
    end
  end

  always_comb begin
    st_we    = 1'b0;
    st_waddr = node_fill[NA_W-1:0];
    st_wdata = '0;
    if (key_we) begin
      st_we = 1'b1;
    end else if (ctrl.edge_inc) begin
      st_we    = 1'b1;
      st_waddr = tgt_slot;
      st_wdata = {st_rdata[SW-1], st_rdata[PC_W-1:0] + PC_W'(1)};
    end else if (dec_we) begin
      st_we    = 1'b1;
      st_waddr = d_addr;
      st_wdata = {dec_cur[SW-1], dec_cur[PC_W-1:0] - PC_W'(1)};
    end else if (ctrl.mark) begin
      st_we    = 1'b1;
      st_waddr = sel_slot;
      st_wdata = {1'b1, PC_W'(0)};
    end
  end

  dgto_ram #(.WIDTH(KEY_BITS), .DEPTH(MAX_NODES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (node_fill[NA_W-1:0]),
    .wdata (skey),
    .raddr (ncnt[NA_W-1:0]),
    .rdata (key_rdata)
  );

  dgto_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  dgto_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (ctrl.edge_append),
    .waddr (edge_fill[EA_W-1:0]),
    .wdata ({src_slot, tgt_slot}),
    .raddr (ecnt[EA_W-1:0]),
    .rdata (edge_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      node_fill <= '0;
      edge_fill <= '0;
      ncnt      <= '0;
      ecnt      <= '0;
      n_pv      <= 1'b0;
      e_pv      <= 1'b0;
      d_pv      <= 1'b0;
      fwd_valid <= 1'b0;
      src_hit   <= 1'b0;
      tgt_hit   <= 1'b0;
      rdy_hit   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        node_fill <= '0;
        edge_fill <= '0;
      end else begin
        if (key_we) begin
          node_fill <= node_fill + NF_W'(1);
        end
        if (ctrl.edge_append) begin
          edge_fill <= edge_fill + EF_W'(1);
        end
      end

      if (ctrl.scan_start) begin
        ncnt    <= '0;
        ecnt    <= '0;
        src_hit <= 1'b0;
        tgt_hit <= 1'b0;
        rdy_hit <= 1'b0;
      end else begin
        if (n_issue) begin
          ncnt <= ncnt + NF_W'(1);
        end
        if (e_issue) begin
          ecnt <= ecnt + EF_W'(1);
        end
        if (ctrl.lookup_run && n_pv && !src_hit && (key_rdata == skey)) begin
          src_hit <= 1'b1;
        end
        if (ctrl.lookup_run && n_pv && !tgt_hit && (key_rdata == tkey)) begin
          tgt_hit <= 1'b1;
        end
        if (hit_now) begin
          rdy_hit <= 1'b1;
        end
      end

      n_pv      <= n_issue;
      e_pv      <= e_issue;
      d_pv      <= e_match;
      fwd_valid <= dec_we;

      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_r <= dgto_pkg::cmd_t'(cmd);
      skey  <= KEY_BITS'(column_key);
      tkey  <= KEY_BITS'(target_key);
    end
    n_paddr <= ncnt[NA_W-1:0];
    if (ctrl.lookup_run && n_pv && !src_hit && (key_rdata == skey)) begin
      src_slot <= n_paddr;
    end
    if (ctrl.lookup_run && n_pv && !tgt_hit && (key_rdata == tkey)) begin
      tgt_slot <= n_paddr;
    end
    if (hit_now) begin
      sel_slot <= n_paddr;
      sel_key  <= key_rdata;
    end
    d_addr   <= et;
    fwd_addr <= st_waddr;
    fwd_data <= st_wdata;
    if (ctrl.res_wr) begin
      res_found  <= ctrl.res_found;
      res_status <= ctrl.res_status;
    end
    if (ctrl.load_out) begin
      found     <= res_found;
      ready_key <= res_found ? KW'(sel_key) : '0;
      status_r  <= res_status;
    end
  end

  assign status = status_r;

  always_comb begin
    stat.cmd         = cmd_r;
    stat.node_full   = node_full;
    stat.edge_full   = edge_full;
    stat.lookup_done = (ncnt >= node_fill) && !n_pv;
    stat.src_hit     = src_hit;
    stat.tgt_hit     = tgt_hit;
    stat.ready_done  = rdy_hit || ((ncnt >= node_fill) && !n_pv);
    stat.ready_hit   = rdy_hit;
    stat.edge_done   = (ecnt >= edge_fill) && !e_pv && !d_pv;
    stat.out_free    = !out_valid || !out_stall;
  end

  `DGTO_ASSERT_NOW(a_node_fill_bound, 1'b1, node_fill <= NF_W'(MAX_NODES), "node fill overrun")
  `DGTO_ASSERT_NOW(a_edge_fill_bound, 1'b1, edge_fill <= EF_W'(MAX_EDGES), "edge fill overrun")
  `DGTO_ASSERT_NOW(a_sel_in_range, ctrl.mark, NF_W'(sel_slot) < node_fill, "ready slot past fill")
  `DGTO_ASSERT_NOW(a_append_legal, ctrl.edge_append, src_hit && tgt_hit && !edge_full, "bad append")
  `DGTO_ASSERT_NEXT(a_found_ok, ctrl.load_out && res_found, status_r == dgto_pkg::ST_OK, "found not ok")

endmodule

FILE: rtl/core/dgto_ctrl.sv
// controller state machine sequencing each command through the datapath
// uses dgto_pkg
`timescale 1ns / 1ps

module dgto_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  dgto_pkg::stat_t stat,
  output dgto_pkg::ctrl_t ctrl
);

  dgto_pkg::ctrl_state_t state;
  dgto_pkg::ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dgto_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != dgto_pkg::S_IDLE);

  always_comb begin
    state_next      = state;
    ctrl            = '0;
    ctrl.res_status = dgto_pkg::ST_OK;
    unique case (state)
      dgto_pkg::S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_next  = dgto_pkg::S_DISPATCH;
        end
      end
      dgto_pkg::S_DISPATCH: begin
        unique case (stat.cmd)
          dgto_pkg::CMD_ADD_NODE: begin
            ctrl.add_node   = 1'b1;
            ctrl.res_wr     = 1'b1;
            ctrl.res_status = stat.node_full ? dgto_pkg::ST_FULL : dgto_pkg::ST_OK;
            state_next      = dgto_pkg::S_RESPOND;
          end
          dgto_pkg::CMD_ADD_EDGE: begin
            ctrl.scan_start = 1'b1;
            state_next      = dgto_pkg::S_LOOKUP;
          end
          dgto_pkg::CMD_TAKE: begin
            ctrl.scan_start = 1'b1;
            state_next      = dgto_pkg::S_READY_SCAN;
          end
          dgto_pkg::CMD_CLEAR: begin
            ctrl.clear  = 1'b1;
            ctrl.res_wr = 1'b1;
            state_next  = dgto_pkg::S_RESPOND;
          end
          default: state_next = dgto_pkg::S_RESPOND;
        endcase
      end
      dgto_pkg::S_LOOKUP: begin
        ctrl.lookup_run = 1'b1;
        if (stat.lookup_done) begin
          // unknown key wins over a full edge table
          if (!(stat.src_hit && stat.tgt_hit)) begin
            ctrl.res_wr     = 1'b1;
            ctrl.res_status = dgto_pkg::ST_UNKNOWN;
            state_next      = dgto_pkg::S_RESPOND;
          end else if (stat.edge_full) begin
            ctrl.res_wr     = 1'b1;
            ctrl.res_status = dgto_pkg::ST_FULL;
            state_next      = dgto_pkg::S_RESPOND;
          end else begin
            state_next = dgto_pkg::S_EDGE_APPEND;
          end
        end
      end
      dgto_pkg::S_EDGE_APPEND: begin
        ctrl.edge_append = 1'b1;
        state_next       = dgto_pkg::S_EDGE_INC;
      end
      dgto_pkg::S_EDGE_INC: begin
        ctrl.edge_inc = 1'b1;
        ctrl.res_wr   = 1'b1;
        state_next    = dgto_pkg::S_RESPOND;
      end
      dgto_pkg::S_READY_SCAN: begin
        ctrl.ready_run = 1'b1;
        if (stat.ready_done) begin
          if (stat.ready_hit) begin
            state_next = dgto_pkg::S_EDGE_SCAN;
          end else begin
            ctrl.res_wr     = 1'b1;
            ctrl.res_status = dgto_pkg::ST_NONE;
            state_next      = dgto_pkg::S_RESPOND;
          end
        end
      end
      dgto_pkg::S_EDGE_SCAN: begin
        ctrl.edge_run = 1'b1;
        if (stat.edge_done) begin
          state_next = dgto_pkg::S_MARK;
        end
      end
      dgto_pkg::S_MARK: begin
        ctrl.mark      = 1'b1;
        ctrl.res_wr    = 1'b1;
        ctrl.res_found = 1'b1;
        state_next     = dgto_pkg::S_RESPOND;
      end
      dgto_pkg::S_RESPOND: begin
        if (stat.out_free) begin
          ctrl.load_out = 1'b1;
          state_next    = dgto_pkg::S_IDLE;
        end
      end
      default: state_next = dgto_pkg::S_IDLE;
    endcase
  end

endmodule
